// ----- sv/mqfd_pkg.sv -----
package mqfd_pkg;

  // Offset within a frame, saturating at the start of the message body
  localparam int unsigned POS_W = 6;

  localparam logic [POS_W-1:0] SIZE_LAST    = 6'd3;
  localparam logic [POS_W-1:0] SIZE_END     = 6'd4;
  localparam logic [POS_W-1:0] TYPE_LAST    = 6'd7;
  localparam logic [POS_W-1:0] HEADER_END   = 6'd8;
  localparam logic [POS_W-1:0] ATTEMPTS_AT  = 6'd16;
  localparam logic [POS_W-1:0] ATTEMPTS_END = 6'd18;
  localparam logic [POS_W-1:0] MSG_BODY_AT  = 6'd34;

  localparam logic [31:0] MIN_FRAME_SIZE = 32'd4;
  localparam logic [31:0] MSG_MIN_SIZE   = 32'd30;
  localparam logic [31:0] TYPE_MSG_CODE  = 32'd2;

  // Section tag carried with every byte
  typedef enum logic [2:0] {
    SEC_SIZE      = 3'd0,
    SEC_TYPE      = 3'd1,
    SEC_TIMESTAMP = 3'd2,
    SEC_ATTEMPTS  = 3'd3,
    SEC_MSG_ID    = 3'd4,
    SEC_DATA      = 3'd5,
    SEC_SKIP      = 3'd6
  } section_t;

  // Frame kind
  typedef enum logic [1:0] {
    KIND_RESPONSE = 2'd0,
    KIND_ERROR    = 2'd1,
    KIND_MESSAGE  = 2'd2,
    KIND_INVALID  = 2'd3
  } kind_t;

  // One tagged byte
  typedef struct packed {
    section_t    section;
    logic [7:0]  byte_out;
    kind_t       frame_kind;
    logic        kind_valid;
    logic [31:0] frame_size;
    logic [63:0] timestamp_ns;
    logic [15:0] attempt_count;
    logic        frame_end;
  } result_t;

endpackage

// ----- sv/mqfd_decoder.sv -----
module mqfd_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          byte_in,
  output mqfd_pkg::result_t   result
);
  import mqfd_pkg::*;

  logic [POS_W-1:0] pos_r,   pos_nxt;
  logic [31:0]      size_r,  size_nxt;
  logic [31:0]      type_r,  type_nxt;
  kind_t            kind_r,  kind_nxt;
  logic             known_r, known_nxt;
  logic [63:0]      ts_r,    ts_nxt;
  logic [15:0]      att_r,   att_nxt;
  logic [31:0]      left_r,  left_nxt;

  logic             first;
  logic             frame_end;
  section_t         section;

  // Decode one byte against the current frame state
  always_comb begin
    first     = (pos_r == '0);
    size_nxt  = first ? '0 : size_r;
    type_nxt  = first ? '0 : type_r;
    kind_nxt  = first ? KIND_RESPONSE : kind_r;
    known_nxt = first ? 1'b0 : known_r;
    ts_nxt    = first ? '0 : ts_r;
    att_nxt   = first ? '0 : att_r;
    left_nxt  = left_r;
    frame_end = 1'b0;
    section   = SEC_SIZE;

    if (pos_r < SIZE_END) begin
      section  = SEC_SIZE;
      size_nxt = {size_nxt[23:0], byte_in};
      if (pos_r == SIZE_LAST) begin
        left_nxt  = size_nxt;
        frame_end = (size_nxt == '0);
        if (size_nxt < MIN_FRAME_SIZE) begin
          kind_nxt  = KIND_INVALID;
          known_nxt = 1'b1;
        end
      end
    end else begin
      left_nxt  = left_r - 32'd1;
      frame_end = (left_nxt == '0);
      if (known_nxt && kind_nxt == KIND_INVALID) begin
        section = SEC_SKIP;
      end else if (pos_r < HEADER_END) begin
        section  = SEC_TYPE;
        type_nxt = {type_nxt[23:0], byte_in};
        if (pos_r == TYPE_LAST) begin
          if (type_nxt > TYPE_MSG_CODE) begin
            kind_nxt = KIND_INVALID;
          end else if (type_nxt == TYPE_MSG_CODE && size_nxt < MSG_MIN_SIZE) begin
            kind_nxt = KIND_INVALID;
          end else begin
            kind_nxt = kind_t'(type_nxt[1:0]);
          end
          known_nxt = 1'b1;
        end
      end else if (kind_nxt != KIND_MESSAGE) begin
        section = SEC_DATA;
      end else if (pos_r < ATTEMPTS_AT) begin
        section = SEC_TIMESTAMP;
        ts_nxt  = {ts_nxt[55:0], byte_in};
      end else if (pos_r < ATTEMPTS_END) begin
        section = SEC_ATTEMPTS;
        att_nxt = {att_nxt[7:0], byte_in};
      end else if (pos_r < MSG_BODY_AT) begin
        section = SEC_MSG_ID;
      end else begin
        section = SEC_DATA;
      end
    end

    // Advance offset; hold it once the body starts
    if (frame_end) begin
      pos_nxt = '0;
    end else if (pos_r < MSG_BODY_AT) begin
      pos_nxt = pos_r + 6'd1;
    end else begin
      pos_nxt = pos_r;
    end

    result.section       = section;
    result.byte_out      = byte_in;
    result.frame_kind    = known_nxt ? kind_nxt : KIND_RESPONSE;
    result.kind_valid    = known_nxt;
    result.frame_size    = size_nxt;
    result.timestamp_ns  = ts_nxt;
    result.attempt_count = att_nxt;
    result.frame_end     = frame_end;
  end

  // Frame offset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (step) begin
      pos_r <= pos_nxt;
    end
  end

  // Decoded fields; cleared on the first byte of each frame
  always_ff @(posedge clk) begin
    if (step) begin
      size_r  <= size_nxt;
      type_r  <= type_nxt;
      kind_r  <= kind_nxt;
      known_r <= known_nxt;
      ts_r    <= ts_nxt;
      att_r   <= att_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

// ----- sv/message_queue_frame_deframer_core.sv -----
// Frame stream tagger. Takes one raw byte per beat and returns one tagged
// byte per beat: its section within the frame (size, type, timestamp,
// attempts, message id, data/body or skipped), the frame kind once the
// type field is complete, the decoded size, timestamp and attempts count,
// and a flag on the final byte of each frame. A frame whose type is not
// response, error or message, or whose size is too short for its kind, is
// marked invalid and its remaining bytes are tagged as skipped. Throughput
// is one byte per clock while the output is not stalled. Each beat is
// first captured in the input register; its decode is then loaded into
// the result register, which drives the result port, once that register
// has room. While a finished result waits to be taken, the input accepts
// one more beat into its register and then stalls.
module message_queue_frame_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_section,
  output logic [7:0]  out_byte_out,
  output logic [1:0]  out_frame_kind,
  output logic        out_kind_valid,
  output logic [31:0] out_frame_size,
  output logic [63:0] out_timestamp_ns,
  output logic [15:0] out_attempt_count,
  output logic        out_frame_end
);
  import mqfd_pkg::*;

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    result_r;
  result_t    result;
  logic       out_ready;
  logic       step;
  logic       in_fire;

  // Handshake: move the input beat into the result register when it has room
  assign out_ready = !out_valid_r || !out_stall;
  assign step      = in_valid_r && out_ready;
  assign in_stall  = in_valid_r && !out_ready;
  assign in_fire   = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_fire) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  mqfd_decoder u_decoder (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (in_byte_r),
    .result  (result)
  );

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture input beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_stream_byte;
    end
  end

  // Capture result beat
  always_ff @(posedge clk) begin
    if (step) begin
      result_r <= result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_section       = result_r.section;
  assign out_byte_out      = result_r.byte_out;
  assign out_frame_kind    = result_r.frame_kind;
  assign out_kind_valid    = result_r.kind_valid;
  assign out_frame_size    = result_r.frame_size;
  assign out_timestamp_ns  = result_r.timestamp_ns;
  assign out_attempt_count = result_r.attempt_count;
  assign out_frame_end     = result_r.frame_end;

endmodule
